[sv/sutv_pkg.sv]
// sutv_pkg: widths and register indexes shared by the Sutherland viscosity block.
// Depends on nothing; compiled first.
package sutv_pkg;

  // limb width of the wide-by-narrow multiplier; every factor fits in one limb
  localparam int LIMB_W = 34;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam int TEMP_W = 32;
  localparam int RES_W  = 64;

  // remainder width of the root lanes, covers 2^128 times the widest divisor
  localparam int ROOT_W = 360;

  localparam logic [CFG_IDX_W-1:0] CFG_MU_REF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_T_REF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUTH_S = 2'd2;

endpackage

[sv/sutherland_viscosity.sv]
// sutherland_viscosity: Sutherland law viscosity and slope, one temperature per cycle unless the output stalls.
// Depends on sutv_pkg and sutv_mul.
//
// Usage
//   Input channel: temperature (unsigned Q16.16 kelvin) with temp_valid / temp_stall.
//   Output channel: viscosity (Q16.48), viscosity_slope (Q8.56) and math_error with
//   result_valid / result_stall. A word moves on an edge where valid is high and
//   stall is low.
//   Configuration: cfg_we, cfg_index, cfg_data; index 0 mu_ref, 1 t_ref,
//   2 sutherland_const, other indexes ignored. Write only while the block is empty.
//   Pipeline: 78 stages (one input stage, 12 stages of operand delay and limb
//   multipliers that build the squared-result numerator and denominator, 64 stages
//   of bit-serial root, one output stage); throughput one word per cycle while
//   result_stall does not hold the pipe.
//   Each result is floor(sqrt(N/D)) found one bit per stage, with no divider:
//   the stage keeps N - v^2*D and v*D and tries the next bit with shifts and adds.
//   math_error forces both results to zero when t_ref is zero or T+S is zero.
//   Reset: synchronous, active high; clears the configuration registers and empties the pipe.
//   Stall: while a result waits and result_stall is high the whole pipe holds and
//   temp_stall is raised; nothing is lost or repeated.
module sutherland_viscosity (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sutv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sutv_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              temp_valid,
  output logic                              temp_stall,
  input  logic [sutv_pkg::TEMP_W-1:0]       temperature,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [sutv_pkg::RES_W-1:0]        viscosity,
  output logic [sutv_pkg::RES_W-1:0]        viscosity_slope,
  output logic                              math_error
);
  import sutv_pkg::*;

  localparam int ROOT_IN = 12;                 // stage holding N and D
  localparam int LAST    = ROOT_IN + RES_W + 1; // output stage

  // config registers
  logic [47:0] mu_ref;
  logic [31:0] t_ref;
  logic [31:0] suth_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_ref <= '0;
      t_ref  <= '0;
      suth_s <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MU_REF: mu_ref <= cfg_data[47:0];
        CFG_T_REF:  t_ref  <= cfg_data[31:0];
        CFG_SUTH_S: suth_s <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // pipe control: everything holds while the output word is stalled
  logic            en;
  logic [LAST:0]   vld;
  logic [LAST-1:0] err_d;

  assign en           = !(vld[LAST] && result_stall);
  assign temp_stall   = !en;
  assign result_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], temp_valid};
    end
  end

  // config-only products, free running; settle well before an item needs them
  // c3 = (mu_ref * (t_ref + S))^2, 7 registers deep; r3 = t_ref^3, 4 deep
  logic [32:0]  rs;
  logic [80:0]  c1;
  logic [113:0] c2;
  logic [137:0] pl;
  logic [137:0] ph;
  logic [161:0] c3;
  logic [63:0]  r2;
  logic [95:0]  r3;

  assign rs = 33'(t_ref) + 33'(suth_s);

  sutv_mul #(.XW(48),  .FW(33)) u_c1 (.clk, .en(1'b1), .x(mu_ref), .f(rs), .p(c1));
  sutv_mul #(.XW(81),  .FW(33)) u_c2 (.clk, .en(1'b1), .x(c1), .f(rs), .p(c2));
  sutv_mul #(.XW(114), .FW(24)) u_pl (.clk, .en(1'b1), .x(c2), .f(mu_ref[23:0]), .p(pl));
  sutv_mul #(.XW(114), .FW(24)) u_ph (.clk, .en(1'b1), .x(c2), .f(mu_ref[47:24]), .p(ph));

  always_ff @(posedge clk) begin
    c3 <= 162'(pl) + (162'(ph) << 24);
  end

  sutv_mul #(.XW(32), .FW(32)) u_r2 (.clk, .en(1'b1), .x(t_ref), .f(t_ref), .p(r2));
  sutv_mul #(.XW(64), .FW(32)) u_r3 (.clk, .en(1'b1), .x(r2), .f(t_ref), .p(r3));

  // input stage and operand delay lines
  logic        err0;
  logic [31:0] t_d   [0:10];
  logic [32:0] ts_d  [0:10];
  logic [33:0] t3s_d [0:10];

  assign err0 = (t_ref == '0) || ((temperature == '0) && (suth_s == '0));

  always_ff @(posedge clk) begin
    if (en) begin
      t_d[0]   <= temperature;
      ts_d[0]  <= 33'(temperature) + 33'(suth_s);
      t3s_d[0] <= 34'(temperature) + 34'(suth_s) + {1'b0, suth_s, 1'b0};
      for (int k = 1; k <= 10; k++) begin
        t_d[k]   <= t_d[k-1];
        ts_d[k]  <= ts_d[k-1];
        t3s_d[k] <= t3s_d[k-1];
      end
      err_d <= {err_d[LAST-2:0], err0};
    end
  end

  // denominators: d1 = r^3 (T+S)^2 at stage 8, d2 = r^3 (T+S)^4 at stage 12
  logic [128:0] da;
  logic [161:0] d1;
  logic [194:0] db;
  logic [227:0] d2;
  logic [161:0] d1_dly [4];

  sutv_mul #(.XW(96),  .FW(33)) u_da (.clk, .en, .x(r3), .f(ts_d[4]),  .p(da));
  sutv_mul #(.XW(129), .FW(33)) u_d1 (.clk, .en, .x(da), .f(ts_d[6]),  .p(d1));
  sutv_mul #(.XW(162), .FW(33)) u_db (.clk, .en, .x(d1), .f(ts_d[8]),  .p(db));
  sutv_mul #(.XW(195), .FW(33)) u_d2 (.clk, .en, .x(db), .f(ts_d[10]), .p(d2));

  always_ff @(posedge clk) begin
    if (en) begin
      d1_dly[0] <= d1;
      for (int k = 1; k < 4; k++) begin
        d1_dly[k] <= d1_dly[k-1];
      end
    end
  end

  // numerators: n1 = c3 T^3, n2 = c3 T (T+3S)^2, both at stage 12
  logic [193:0] na;
  logic [225:0] n1b;
  logic [257:0] n1;
  logic [227:0] n2b;
  logic [261:0] n2;

  sutv_mul #(.XW(162), .FW(32)) u_na  (.clk, .en, .x(c3),  .f(t_d[6]),    .p(na));
  sutv_mul #(.XW(194), .FW(32)) u_n1b (.clk, .en, .x(na),  .f(t_d[8]),    .p(n1b));
  sutv_mul #(.XW(226), .FW(32)) u_n1  (.clk, .en, .x(n1b), .f(t_d[10]),   .p(n1));
  sutv_mul #(.XW(194), .FW(34)) u_n2b (.clk, .en, .x(na),  .f(t3s_d[8]),  .p(n2b));
  sutv_mul #(.XW(228), .FW(34)) u_n2  (.clk, .en, .x(n2b), .f(t3s_d[10]), .p(n2));

  // root lanes: lane 0 viscosity, lane 1 slope (numerator carries 2^46)
  logic [ROOT_W-1:0] root_n [2];
  logic [ROOT_W-1:0] root_d [2];

  assign root_n[0] = ROOT_W'(n1);
  assign root_n[1] = ROOT_W'(n2) << 46;
  assign root_d[0] = ROOT_W'(d1_dly[3]);
  assign root_d[1] = ROOT_W'(d2);

  logic [ROOT_W-1:0] rem_q [2][1:RES_W];
  logic [ROOT_W-1:0] pv_q  [2][1:RES_W];
  logic [ROOT_W-1:0] den_q [2][1:RES_W];
  logic [RES_W-1:0]  res_q [2][1:RES_W];

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    for (genvar j = 1; j <= RES_W; j++) begin : g_bit
      localparam int B = RES_W - j;
      logic [ROOT_W-1:0] r_in;
      logic [ROOT_W-1:0] p_in;
      logic [ROOT_W-1:0] d_in;
      logic [RES_W-1:0]  v_in;
      logic [ROOT_W-1:0] trial;
      logic              take;

      if (j == 1) begin : g_first
        assign r_in = root_n[ln];
        assign p_in = '0;
        assign d_in = root_d[ln];
        assign v_in = '0;
      end else begin : g_next
        assign r_in = rem_q[ln][j-1];
        assign p_in = pv_q[ln][j-1];
        assign d_in = den_q[ln][j-1];
        assign v_in = res_q[ln][j-1];
      end

      // (v + 2^B)^2 D - v^2 D = 2^(B+1) vD + 2^(2B) D
      assign trial = (p_in << (B + 1)) + (d_in << (2 * B));
      assign take  = r_in >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[ln][j] <= take ? r_in - trial : r_in;
          pv_q[ln][j]  <= take ? p_in + (d_in << B) : p_in;
          den_q[ln][j] <= d_in;
          res_q[ln][j] <= take ? (v_in | (RES_W'(1) << B)) : v_in;
        end
      end
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (en) begin
      viscosity       <= err_d[LAST-1] ? '0 : res_q[0][RES_W];
      viscosity_slope <= err_d[LAST-1] ? '0 : res_q[1][RES_W];
      math_error      <= err_d[LAST-1];
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && math_error |-> viscosity == '0 && viscosity_slope == '0)
    else $error("error word carries nonzero results");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    temp_stall |-> result_valid && result_stall)
    else $error("input stalled with no output stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid straight after reset");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    temp_valid && !temp_stall |=> vld[0])
    else $error("accepted word not entered into pipe");
`endif

endmodule

[sv/sutv_mul.sv]
// sutv_mul: pipelined wide-by-narrow unsigned multiplier, two register stages.
// Depends on sutv_pkg (limb width).
module sutv_mul #(
  parameter int XW = 64,
  parameter int FW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] x,
  input  logic [FW-1:0] f,
  output logic [XW+FW-1:0] p
);
  import sutv_pkg::*;

  localparam int LW = LIMB_W;
  localparam int NL = (XW + LW - 1) / LW;
  localparam int PW = LW + FW;
  localparam int SW = NL * LW + FW;

  logic [NL*LW-1:0] xe;
  logic [PW-1:0]    prod [NL];
  logic [SW-1:0]    ev;
  logic [SW-1:0]    od;
  logic [SW-1:0]    sum;

  assign xe = (NL*LW)'(x);

  // stage 1: one limb product each
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NL; i++) begin
        prod[i] <= PW'(xe[i*LW +: LW]) * PW'(f);
      end
    end
  end

  // even and odd limb products do not overlap, so one add merges them
  always_comb begin
    ev = '0;
    od = '0;
    for (int i = 0; i < NL; i++) begin
      if ((i % 2) == 0) begin
        ev[i*LW +: PW] = prod[i];
      end else begin
        od[i*LW +: PW] = prod[i];
      end
    end
    sum = ev + od;
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (en) begin
      p <= sum[XW+FW-1:0];
    end
  end

endmodule
